// File: hw/rtl/load_shedding_controller_macros.svh
// ---------------------------------------------------------------------------
// Load-shedding controller assertion macros
// Shared concurrent assertion forms for the RTL of the controller.
// ---------------------------------------------------------------------------
`ifndef LOAD_SHEDDING_CONTROLLER_MACROS_SVH
`define LOAD_SHEDDING_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked assertion that is disabled while reset is high.
`define LSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define LSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSC_ASSERT(lbl, clk, rst, prop, msg)
`define LSC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hw/rtl/lsc_pkg.sv
// ---------------------------------------------------------------------------
// Load-shedding controller package
// Command and load state codes, field widths and the request/response types.
// ---------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

   // Field widths of the request and response.
   localparam int CMD_W  = 3;
   localparam int IDX_W  = 3;
   localparam int SW_W   = 5;
   localparam int MASK_W = 5;
   localparam int TICK_W = 16;

   // Default number of loads and the reset grace period.
   localparam int                NUM_LOADS_DEFAULT = 5;
   localparam logic [TICK_W-1:0] GRACE_TICKS_RESET = 16'd500;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_BUTTON   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_STABLE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UNSTABLE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SWITCH_ON  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SWITCH_OFF = 3'd4;
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd5;

   // Per-load state codes.
   typedef logic [1:0] load_state_type;
   localparam load_state_type ST_ENABLED  = 2'd0;
   localparam load_state_type ST_SHED     = 2'd1;
   localparam load_state_type ST_DISABLED = 2'd2;

   // One request as it travels from the input stage to the core.
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [IDX_W-1:0] load_index;
      logic [SW_W-1:0]  switch_vector;
   } item_type;

   // One response as the core hands it to the output register.
   typedef struct packed {
      logic [MASK_W-1:0] enabled_mask;
      logic [MASK_W-1:0] shed_mask;
      logic              managing;
      logic              in_maintenance;
      logic              grace_active;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/lsc_core.sv
// ---------------------------------------------------------------------------
// Load-shedding controller core
// Load states, counts, mode flags and grace timer, updated once per request.
// ---------------------------------------------------------------------------
`default_nettype none

`include "load_shedding_controller_macros.svh"

module lsc_core
   import lsc_pkg::*;
#(
   parameter int NUM_LOADS = NUM_LOADS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire item_type          item,
   input  wire logic [TICK_W-1:0] grace_ticks,
   output result_type             result
);

   localparam int CNT_W = $clog2(NUM_LOADS + 1);

   // State registers.
   load_state_type [NUM_LOADS-1:0] st_ff, st_in;
   logic [CNT_W-1:0]  en_cnt_ff, en_cnt_in;
   logic [CNT_W-1:0]  mg_cnt_ff, mg_cnt_in;
   logic              mgmt_ff, mgmt_in;
   logic              maint_ff, maint_in;
   logic              shedding_ff, shedding_in;
   logic              grace_ff, grace_in;
   logic              run_ff, run_in;
   logic [TICK_W-1:0] tcount_ff, tcount_in;

   // Helper signals.
   logic [NUM_LOADS-1:0] en_pick, sh_pick, hit;
   logic                 en_found, sh_found, in_range;
   load_state_type       addr_state;
   load_state_type [NUM_LOADS-1:0] rl_st;
   logic [CNT_W-1:0]     rl_on;
   logic [NUM_LOADS+SW_W-1:0] sw_ext;
   logic [TICK_W:0]      tcount_inc, period;
   logic                 do_shed, do_restore, do_reload, do_write;
   load_state_type       write_st;

   // Lowest-index enabled and shed loads, and the addressed load.
   always_comb begin
      en_found   = 1'b0;
      sh_found   = 1'b0;
      en_pick    = '0;
      sh_pick    = '0;
      hit        = '0;
      addr_state = ST_DISABLED;
      for (int i = 0; i < NUM_LOADS; i++) begin
         if (!en_found && st_ff[i] == ST_ENABLED) begin
            en_pick[i] = 1'b1;
            en_found   = 1'b1;
         end
         if (!sh_found && st_ff[i] == ST_SHED) begin
            sh_pick[i] = 1'b1;
            sh_found   = 1'b1;
         end
         if (32'(item.load_index) == i) begin
            hit[i]     = 1'b1;
            addr_state = st_ff[i];
         end
      end
      in_range = |hit;
   end

   // Reload image from the switch vector; loads without a switch read as off.
   assign sw_ext = {{NUM_LOADS{1'b0}}, item.switch_vector};

   always_comb begin
      rl_on = '0;
      for (int i = 0; i < NUM_LOADS; i++) begin
         if (i < SW_W && sw_ext[i]) begin
            rl_st[i] = ST_ENABLED;
            rl_on    = rl_on + CNT_W'(1);
         end else begin
            rl_st[i] = ST_DISABLED;
         end
      end
   end

   // Timer step; a zero period acts as one.
   assign tcount_inc = {1'b0, tcount_ff} + {{TICK_W{1'b0}}, 1'b1};
   assign period     = (grace_ticks == '0) ? {{TICK_W{1'b0}}, 1'b1} : {1'b0, grace_ticks};

   // Command decode and next-state selection.
   always_comb begin
      en_cnt_in   = en_cnt_ff;
      mg_cnt_in   = mg_cnt_ff;
      mgmt_in     = mgmt_ff;
      maint_in    = maint_ff;
      shedding_in = shedding_ff;
      grace_in    = grace_ff;
      run_in      = run_ff;
      tcount_in   = tcount_ff;
      do_shed     = 1'b0;
      do_restore  = 1'b0;
      do_reload   = 1'b0;
      do_write    = 1'b0;
      write_st    = ST_DISABLED;

      unique case (item.command)
         CMD_BUTTON: begin
            maint_in = !maint_ff;
            if (!maint_ff) begin
               mgmt_in   = 1'b0;
               do_reload = 1'b1;
            end
         end
         CMD_STABLE: begin
            shedding_in = 1'b0;
            if (!maint_ff) begin
               if (en_cnt_ff < mg_cnt_ff) begin
                  grace_in  = 1'b1;
                  run_in    = 1'b1;
                  tcount_in = '0;
               end else begin
                  mgmt_in = 1'b0;
                  if (grace_ff) begin
                     grace_in  = 1'b0;
                     run_in    = 1'b0;
                     tcount_in = '0;
                  end
               end
            end
         end
         CMD_UNSTABLE: begin
            shedding_in = 1'b1;
            mgmt_in     = 1'b1;
            if (!maint_ff) begin
               if (grace_ff) begin
                  grace_in  = (en_cnt_ff != '0);
                  run_in    = (en_cnt_ff != '0);
                  tcount_in = '0;
               end else if (en_cnt_ff > CNT_W'(1)) begin
                  do_shed   = 1'b1;
                  grace_in  = 1'b1;
                  run_in    = 1'b1;
                  tcount_in = '0;
               end else if (en_cnt_ff == CNT_W'(1)) begin
                  do_shed = 1'b1;
               end
            end
         end
         CMD_SWITCH_ON: begin
            if (maint_ff) begin
               do_reload = 1'b1;
            end else if (in_range && addr_state == ST_DISABLED) begin
               do_write  = 1'b1;
               mg_cnt_in = mg_cnt_ff + CNT_W'(1);
               if (mgmt_ff) begin
                  write_st = ST_SHED;
               end else begin
                  write_st  = ST_ENABLED;
                  en_cnt_in = en_cnt_ff + CNT_W'(1);
               end
            end
         end
         CMD_SWITCH_OFF: begin
            if (maint_ff) begin
               do_reload = 1'b1;
            end else if (in_range && addr_state == ST_ENABLED) begin
               do_write  = 1'b1;
               mg_cnt_in = mg_cnt_ff - CNT_W'(1);
               en_cnt_in = en_cnt_ff - CNT_W'(1);
               if (grace_ff) begin
                  // Restart only when the last managed load went away.
                  grace_in  = (mg_cnt_ff == CNT_W'(1));
                  run_in    = (mg_cnt_ff == CNT_W'(1));
                  tcount_in = '0;
               end
            end else if (in_range && addr_state == ST_SHED) begin
               do_write  = 1'b1;
               mg_cnt_in = mg_cnt_ff - CNT_W'(1);
            end
         end
         CMD_TICK: begin
            if (run_ff) begin
               if (tcount_inc >= period) begin
                  tcount_in = '0;
                  grace_in  = 1'b0;
                  if (!maint_ff) begin
                     if (shedding_ff) begin
                        // Shed one more load, stop once the last one is gone.
                        if (mg_cnt_ff != '0) begin
                           do_shed = 1'b1;
                        end
                        if (mg_cnt_ff <= CNT_W'(1)) begin
                           run_in = 1'b0;
                        end
                     end else begin
                        // Restore one load, leave management on the last one.
                        if ({1'b0, en_cnt_ff} + 1'b1 < {1'b0, mg_cnt_ff}) begin
                           do_restore = 1'b1;
                        end else if ({1'b0, en_cnt_ff} + 1'b1 == {1'b0, mg_cnt_ff}) begin
                           mgmt_in    = 1'b0;
                           do_restore = 1'b1;
                           run_in     = 1'b0;
                        end else begin
                           mgmt_in = 1'b0;
                           run_in  = 1'b0;
                        end
                     end
                  end
               end else begin
                  tcount_in = tcount_inc[TICK_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase

      // Counts follow only a load that was actually found.
      if (do_reload) begin
         en_cnt_in = rl_on;
         mg_cnt_in = rl_on;
      end else if (do_shed && en_found) begin
         en_cnt_in = en_cnt_ff - CNT_W'(1);
      end else if (do_restore && sh_found) begin
         en_cnt_in = en_cnt_ff + CNT_W'(1);
      end
   end

   // Per-load state update.
   always_comb begin
      for (int i = 0; i < NUM_LOADS; i++) begin
         if (do_reload) begin
            st_in[i] = rl_st[i];
         end else if (do_write && hit[i]) begin
            st_in[i] = write_st;
         end else if (do_shed && en_pick[i]) begin
            st_in[i] = ST_SHED;
         end else if (do_restore && sh_pick[i]) begin
            st_in[i] = ST_ENABLED;
         end else begin
            st_in[i] = st_ff[i];
         end
      end
   end

   // State registers, updated on each request taken from the input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= {NUM_LOADS{ST_ENABLED}};
         en_cnt_ff   <= CNT_W'(NUM_LOADS);
         mg_cnt_ff   <= CNT_W'(NUM_LOADS);
         mgmt_ff     <= 1'b0;
         maint_ff    <= 1'b0;
         shedding_ff <= 1'b0;
         grace_ff    <= 1'b0;
         run_ff      <= 1'b0;
         tcount_ff   <= '0;
      end else if (fire) begin
         st_ff       <= st_in;
         en_cnt_ff   <= en_cnt_in;
         mg_cnt_ff   <= mg_cnt_in;
         mgmt_ff     <= mgmt_in;
         maint_ff    <= maint_in;
         shedding_ff <= shedding_in;
         grace_ff    <= grace_in;
         run_ff      <= run_in;
         tcount_ff   <= tcount_in;
      end
   end

   // Response view of the state after the request; only loads 0 to 4 show.
   for (genvar i = 0; i < MASK_W; i++) begin : g_mask
      if (i < NUM_LOADS) begin : g_load
         assign result.enabled_mask[i] = (st_in[i] == ST_ENABLED);
         assign result.shed_mask[i]    = (st_in[i] == ST_SHED);
      end else begin : g_none
         assign result.enabled_mask[i] = 1'b0;
         assign result.shed_mask[i]    = 1'b0;
      end
   end

   assign result.managing       = mgmt_in;
   assign result.in_maintenance = maint_in;
   assign result.grace_active   = grace_in;

   // Consistency of counts, flags and timer.
   `LSC_ASSERT(a_cnt_order, clock, reset, en_cnt_ff <= mg_cnt_ff,
               "enabled count exceeds managed count")
   `LSC_ASSERT(a_grace_run, clock, reset, grace_ff |-> run_ff,
               "grace period pending without a running timer")
   `LSC_ASSERT(a_idle_count, clock, reset, !run_ff |-> (tcount_ff == '0),
               "stopped timer holds a nonzero count")
   `LSC_ASSERT(a_hold, clock, reset, !fire |=> $stable(st_ff) && $stable(tcount_ff),
               "state changed without a request")

endmodule

`default_nettype wire

// File: hw/rtl/load_shedding_controller.sv
// ---------------------------------------------------------------------------
// Load-shedding controller
// Relay controller that sheds and restores loads on frequency reports.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ channel (valid/ready): a command, a load
//   index and the current switch vector. Each request yields exactly one
//   response on the rsp_ channel with the load masks and mode flags after
//   the command has taken effect.
//   A request is registered on acceptance; once the response register can
//   advance, it updates the state and loads the response register at the
//   same edge, which raises rsp_valid. One request is taken every cycle
//   while the receiver keeps up; the single state update per cycle,
//   feeding the response register, sets that rate.
//   When the receiver stalls, the response register holds its response and
//   the input register holds one more request; req_ready drops only when
//   both are full.
//   The grace period register is written through csr_write_enable and
//   csr_write_data at any clock edge, and should only change while no
//   request is in flight.
//   Reset (synchronous, active high) enables every load, clears all flags
//   and the timer, empties both registers and sets the grace period to 500.
// ---------------------------------------------------------------------------
`default_nettype none

`include "load_shedding_controller_macros.svh"

module load_shedding_controller
   import lsc_pkg::*;
#(
   parameter int NUM_LOADS = NUM_LOADS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Request channel.
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [CMD_W-1:0]  req_command,
   input  wire logic [IDX_W-1:0]  req_load_index,
   input  wire logic [SW_W-1:0]   req_switch_vector,
   // Response channel.
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [MASK_W-1:0]      rsp_enabled_mask,
   output logic [MASK_W-1:0]      rsp_shed_mask,
   output logic                   rsp_managing,
   output logic                   rsp_in_maintenance,
   output logic                   rsp_grace_active,
   // Configuration port.
   input  wire logic              csr_write_enable,
   input  wire logic [TICK_W-1:0] csr_write_data
);

   logic              s1_valid_ff, s1_valid_in;
   item_type          s1_item_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;
   logic [TICK_W-1:0] grace_ticks_ff;
   logic              advance, fire, req_take;
   result_type        core_result;

   // Handshake control.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.command       <= req_command;
         s1_item_ff.load_index    <= req_load_index;
         s1_item_ff.switch_vector <= req_switch_vector;
      end
   end

   // Grace period register.
   always_ff @(posedge clock) begin
      if (reset) begin
         grace_ticks_ff <= GRACE_TICKS_RESET;
      end else if (csr_write_enable) begin
         grace_ticks_ff <= csr_write_data;
      end
   end

   // Controller state and update.
   lsc_core #(
      .NUM_LOADS (NUM_LOADS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (s1_item_ff),
      .grace_ticks (grace_ticks_ff),
      .result      (core_result)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_enabled_mask   = rsp_ff.enabled_mask;
   assign rsp_shed_mask      = rsp_ff.shed_mask;
   assign rsp_managing       = rsp_ff.managing;
   assign rsp_in_maintenance = rsp_ff.in_maintenance;
   assign rsp_grace_active   = rsp_ff.grace_active;

   // A stalled request stays in the input register; a taken one is answered.
   `LSC_ASSERT(a_s1_hold, clock, reset, s1_valid_ff && !advance |=> s1_valid_ff,
               "request lost from the input register")
   `LSC_ASSERT(a_fire_rsp, clock, reset, fire |=> rsp_valid_ff,
               "request taken without a response")

endmodule

`default_nettype wire

// File: tb/sv/tb_load_shedding_controller.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Load-shedding controller testbench
// Drives commands into the controller and checks every response against a
// behavioral model of the relay states, counts, flags and grace timer. The
// run covers directed corner cases, zero and maximum grace periods, a long
// response stall, and randomized command streams under several periods.
// ---------------------------------------------------------------------------

module tb_load_shedding_controller;
   import lsc_pkg::*;

   localparam int LOAD_COUNT    = NUM_LOADS_DEFAULT;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int MAX_GAP       = 13;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 220;
   localparam int LONG_TICKS    = 200;

   // Command codes the controller does not define.
   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [CMD_W-1:0]  req_command;
   logic [IDX_W-1:0]  req_load_index;
   logic [SW_W-1:0]   req_switch_vector;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [MASK_W-1:0] rsp_enabled_mask;
   logic [MASK_W-1:0] rsp_shed_mask;
   logic              rsp_managing;
   logic              rsp_in_maintenance;
   logic              rsp_grace_active;
   logic              csr_write_enable;
   logic [TICK_W-1:0] csr_write_data;

   // Idling controls for the sender and the receiver.
   bit tx_idle_on;
   bit rx_idle_on;
   bit hold_off_request;
   int mismatch_count;

   // Model of the controller state.
   load_state_type    relay_state [LOAD_COUNT];
   int                enabled_loads;
   int                managed_loads;
   bit                managing_q;
   bit                maint_q;
   bit                shedding_q;
   bit                grace_q;
   bit                timer_on;
   int                tick_count;
   logic [TICK_W-1:0] grace_period;

   result_type expected_status [$];

   load_shedding_controller #(
      .NUM_LOADS(LOAD_COUNT)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_load_index     (req_load_index),
      .req_switch_vector  (req_switch_vector),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_enabled_mask   (rsp_enabled_mask),
      .rsp_shed_mask      (rsp_shed_mask),
      .rsp_managing       (rsp_managing),
      .rsp_in_maintenance (rsp_in_maintenance),
      .rsp_grace_active   (rsp_grace_active),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // Free-running clock with a 4 ns period.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // The run is cut off if it hangs.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("load_shedding_controller test failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Relay model
   // ------------------------------------------------------------------

   // Puts the model into its state after reset.
   function automatic void reset_relays();
      for (int i = 0; i < LOAD_COUNT; i++) begin
         relay_state[i] = ST_ENABLED;
      end
      enabled_loads = LOAD_COUNT;
      managed_loads = LOAD_COUNT;
      managing_q    = 1'b0;
      maint_q       = 1'b0;
      shedding_q    = 1'b0;
      grace_q       = 1'b0;
      timer_on      = 1'b0;
      tick_count    = 0;
      grace_period  = GRACE_TICKS_RESET;
   endfunction

   function automatic void restart_grace();
      grace_q    = 1'b1;
      timer_on   = 1'b1;
      tick_count = 0;
   endfunction

   function automatic void halt_grace();
      grace_q    = 1'b0;
      timer_on   = 1'b0;
      tick_count = 0;
   endfunction

   // Sheds the lowest-index enabled load, if there is one.
   function automatic void shed_lowest();
      for (int i = 0; i < LOAD_COUNT; i++) begin
         if (relay_state[i] == ST_ENABLED) begin
            relay_state[i] = ST_SHED;
            enabled_loads--;
            return;
         end
      end
   endfunction

   // Restores the lowest-index shed load, if there is one.
   function automatic void restore_lowest();
      for (int i = 0; i < LOAD_COUNT; i++) begin
         if (relay_state[i] == ST_SHED) begin
            relay_state[i] = ST_ENABLED;
            enabled_loads++;
            return;
         end
      end
   endfunction

   // Maintenance reload: loads without a switch read as off.
   function automatic void reload_relays(input logic [SW_W-1:0] sw);
      int on_count;
      on_count = 0;
      for (int i = 0; i < LOAD_COUNT; i++) begin
         if (i < SW_W && sw[i]) begin
            relay_state[i] = ST_ENABLED;
            on_count++;
         end else begin
            relay_state[i] = ST_DISABLED;
         end
      end
      enabled_loads = on_count;
      managed_loads = on_count;
   endfunction

   // Applies one accepted request to the model and queues its response.
   function automatic void predict_status(input logic [CMD_W-1:0] cmd,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [SW_W-1:0] sw);
      result_type status;
      int period;
      case (cmd)
         CMD_BUTTON: begin
            maint_q = !maint_q;
            if (maint_q) begin
               managing_q = 1'b0;
               reload_relays(sw);
            end
         end
         CMD_STABLE: begin
            shedding_q = 1'b0;
            if (!maint_q) begin
               if (enabled_loads < managed_loads) begin
                  restart_grace();
               end else begin
                  managing_q = 1'b0;
                  if (grace_q) halt_grace();
               end
            end
         end
         CMD_UNSTABLE: begin
            shedding_q = 1'b1;
            managing_q = 1'b1;
            if (!maint_q) begin
               if (grace_q) begin
                  if (enabled_loads > 0) restart_grace();
                  else halt_grace();
               end else if (enabled_loads > 1) begin
                  shed_lowest();
                  restart_grace();
               end else if (enabled_loads == 1) begin
                  shed_lowest();
               end
            end
         end
         CMD_SWITCH_ON: begin
            if (maint_q) begin
               reload_relays(sw);
            end else if (idx < LOAD_COUNT && relay_state[idx] == ST_DISABLED) begin
               managed_loads++;
               if (managing_q) begin
                  relay_state[idx] = ST_SHED;
               end else begin
                  relay_state[idx] = ST_ENABLED;
                  enabled_loads++;
               end
            end
         end
         CMD_SWITCH_OFF: begin
            if (maint_q) begin
               reload_relays(sw);
            end else if (idx < LOAD_COUNT) begin
               if (relay_state[idx] == ST_ENABLED) begin
                  relay_state[idx] = ST_DISABLED;
                  managed_loads--;
                  enabled_loads--;
                  if (grace_q) begin
                     if (managed_loads == 0) restart_grace();
                     else halt_grace();
                  end
               end else if (relay_state[idx] == ST_SHED) begin
                  relay_state[idx] = ST_DISABLED;
                  managed_loads--;
               end
            end
         end
         CMD_TICK: begin
            // A zero period behaves as a period of one tick.
            period = (grace_period == '0) ? 1 : int'(grace_period);
            if (timer_on) begin
               tick_count++;
               if (tick_count >= period) begin
                  tick_count = 0;
                  grace_q    = 1'b0;
                  if (!maint_q) begin
                     if (shedding_q) begin
                        if (managed_loads > 1) begin
                           shed_lowest();
                        end else if (managed_loads == 1) begin
                           shed_lowest();
                           halt_grace();
                        end else begin
                           halt_grace();
                        end
                     end else begin
                        if (enabled_loads < managed_loads - 1) begin
                           restore_lowest();
                        end else if (enabled_loads == managed_loads - 1) begin
                           managing_q = 1'b0;
                           restore_lowest();
                           halt_grace();
                        end else begin
                           managing_q = 1'b0;
                           halt_grace();
                        end
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase

      status = '0;
      for (int i = 0; i < LOAD_COUNT && i < MASK_W; i++) begin
         if (relay_state[i] == ST_ENABLED) status.enabled_mask[i] = 1'b1;
         else if (relay_state[i] == ST_SHED) status.shed_mask[i] = 1'b1;
      end
      status.managing       = managing_q;
      status.in_maintenance = maint_q;
      status.grace_active   = grace_q;
      expected_status.push_back(status);
   endfunction

   // ------------------------------------------------------------------
   // Response checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   task automatic compare_field(input string what, input logic [MASK_W-1:0] got,
                                input logic [MASK_W-1:0] want);
      if (got !== want) report_mismatch(what, int'(got), int'(want));
   endtask

   // Each accepted response is matched against the oldest prediction.
   always @(posedge clock) begin : check_response
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status.size() == 0) begin
            report_mismatch("response with no request pending", 1, 0);
         end else begin
            want = expected_status.pop_front();
            compare_field("enabled_mask", rsp_enabled_mask, want.enabled_mask);
            compare_field("shed_mask", rsp_shed_mask, want.shed_mask);
            compare_field("managing", MASK_W'(rsp_managing), MASK_W'(want.managing));
            compare_field("in_maintenance", MASK_W'(rsp_in_maintenance),
                          MASK_W'(want.in_maintenance));
            compare_field("grace_active", MASK_W'(rsp_grace_active),
                          MASK_W'(want.grace_active));
         end
      end
   end

   // Receiver: waits a random number of cycles before each response while idling
   // is on, and holds off for a long stretch when asked to.
   initial begin : drive_rsp_ready
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall = LONG_HOLD;
         end else begin
            stall = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   // ------------------------------------------------------------------
   // Request and configuration drivers
   // ------------------------------------------------------------------

   // Offers one request, after a random gap while idling is on, and records it once accepted.
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                               input logic [SW_W-1:0] sw);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command       <= cmd;
      req_load_index    <= idx;
      req_switch_vector <= sw;
      req_valid         <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_status(cmd, idx, sw);
   endtask

   // Stops offering requests and lets every response drain.
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_status.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_grace_period(input logic [TICK_W-1:0] value);
      wait_until_idle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      grace_period = value;
   endtask

   // Random request, biased toward the commands that drive the timer and
   // toward leaving maintenance once it is entered.
   task automatic send_random_request();
      int pick;
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] idx;
      pick = $urandom_range(0, 99);
      if (maint_q && pick < 25) cmd = CMD_BUTTON;
      else if (pick < 40) cmd = CMD_TICK;
      else if (pick < 52) cmd = CMD_UNSTABLE;
      else if (pick < 64) cmd = CMD_STABLE;
      else if (pick < 76) cmd = CMD_SWITCH_ON;
      else if (pick < 88) cmd = CMD_SWITCH_OFF;
      else if (pick < 94) cmd = CMD_BUTTON;
      else if (pick < 97) cmd = CMD_SPARE_A;
      else cmd = CMD_SPARE_B;
      if ($urandom_range(0, 9) < 8) idx = IDX_W'($urandom_range(0, LOAD_COUNT - 1));
      else idx = IDX_W'($urandom_range(LOAD_COUNT, 7));
      send_request(cmd, idx, SW_W'($urandom_range(0, 31)));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Corner cases of every command with a one-tick period.
   task automatic test_directed();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      // Reset state, an undefined command and a tick with the timer idle.
      send_request(CMD_SPARE_A, 3'd0, 5'h1F);
      send_request(CMD_TICK, 3'd7, 5'h00);
      write_grace_period(16'd1);
      // Shed on instability, then one more load per expiry.
      send_request(CMD_UNSTABLE, 3'd0, 5'h00);
      send_request(CMD_TICK, 3'd0, 5'h00);
      send_request(CMD_TICK, 3'd0, 5'h00);
      // Restore after stability returns.
      send_request(CMD_STABLE, 3'd0, 5'h00);
      send_request(CMD_TICK, 3'd0, 5'h00);
      // Switch changes while managing, including indexes out of range.
      send_request(CMD_SWITCH_OFF, 3'd4, 5'h00);
      send_request(CMD_SWITCH_ON, 3'd4, 5'h00);
      send_request(CMD_SWITCH_ON, 3'd7, 5'h00);
      send_request(CMD_SWITCH_OFF, 3'd5, 5'h00);
      send_request(CMD_TICK, 3'd0, 5'h00);
      send_request(CMD_TICK, 3'd0, 5'h00);
      send_request(CMD_TICK, 3'd0, 5'h00);
      send_request(CMD_SPARE_B, 3'd7, 5'h1F);
      // Maintenance reloads from the switches whatever the index.
      send_request(CMD_BUTTON, 3'd0, 5'b10101);
      send_request(CMD_SWITCH_ON, 3'd6, 5'h1F);
      send_request(CMD_SWITCH_OFF, 3'd0, 5'h00);
      send_request(CMD_UNSTABLE, 3'd0, 5'h00);
      send_request(CMD_TICK, 3'd0, 5'h00);
      send_request(CMD_BUTTON, 3'd0, 5'h1F);
      // No load to shed or restore leaves the counts alone.
      send_request(CMD_STABLE, 3'd0, 5'h00);
      send_request(CMD_SWITCH_ON, 3'd0, 5'h00);
      send_request(CMD_SWITCH_ON, 3'd1, 5'h00);
      send_request(CMD_UNSTABLE, 3'd0, 5'h00);
      send_request(CMD_UNSTABLE, 3'd0, 5'h00);
      send_request(CMD_SWITCH_OFF, 3'd1, 5'h00);
      send_request(CMD_UNSTABLE, 3'd0, 5'h00);
   endtask

   // A zero period acts as one tick.
   task automatic test_zero_period();
      write_grace_period(16'd0);
      send_request(CMD_BUTTON, 3'd0, 5'h1F);
      send_request(CMD_BUTTON, 3'd0, 5'h00);
      send_request(CMD_UNSTABLE, 3'd0, 5'h00);
      repeat (3) send_request(CMD_TICK, 3'd0, 5'h00);
      send_request(CMD_STABLE, 3'd0, 5'h00);
      repeat (6) send_request(CMD_TICK, 3'd0, 5'h00);
   endtask

   // The widest period keeps the grace period pending through a long run
   // of ticks.
   task automatic test_long_period();
      write_grace_period(16'hFFFF);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      send_request(CMD_BUTTON, 3'd0, 5'h1F);
      send_request(CMD_BUTTON, 3'd0, 5'h00);
      send_request(CMD_UNSTABLE, 3'd0, 5'h00);
      repeat (LONG_TICKS) send_request(CMD_TICK, 3'd0, 5'h00);
   endtask

   // The receiver stalls for a long stretch while requests keep coming.
   task automatic test_backpressure();
      write_grace_period(16'd2);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      hold_off_request = 1'b1;
      repeat (40) send_random_request();
   endtask

   // Random command streams under a range of periods and idling patterns.
   task automatic test_random();
      logic [TICK_W-1:0] period;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: period = 16'd1;
            1: period = 16'd2;
            5: period = 16'd0;
            7: period = TICK_W'($urandom_range(0, 16'hFFFF));
            default: period = TICK_W'($urandom_range(1, 6));
         endcase
         write_grace_period(period);
         tx_idle_on = (phase % 2 == 0);
         rx_idle_on = (phase % 3 != 1);
         repeat (PHASE_ITEMS) send_random_request();
      end
   endtask

   // Main sequence.
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_command       = '0;
      req_load_index    = '0;
      req_switch_vector = '0;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      mismatch_count    = 0;
      hold_off_request  = 1'b0;
      tx_idle_on        = 1'b1;
      rx_idle_on        = 1'b1;
      reset_relays();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_zero_period();
      test_long_period();
      test_backpressure();
      test_random();

      wait_until_idle();
      if (mismatch_count == 0) begin
         $display("load_shedding_controller test passed");
      end else begin
         $display("load_shedding_controller test failed");
      end
      $finish;
   end

endmodule
